FILE: sv/hdrs_pkg.sv
// hdrs_pkg: shared types, record and sub-record tag codes, and the value size table
// for the heap-dump record stripper; no dependencies
package hdrs_pkg;

    localparam int ID_BYTES_DEF = 4;
    localparam int SKIP_W       = 36;
    localparam int PH_W         = 25;
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int MAX_RES      = 5;

    // record tags
    localparam logic [7:0] REC_HEAP_DUMP     = 8'h0C;
    localparam logic [7:0] REC_HEAP_SEGMENT  = 8'h1C;

    // sub-record tags
    localparam logic [7:0] SUB_ROOT_UNKNOWN  = 8'hFF;
    localparam logic [7:0] SUB_ROOT_JNI_GLB  = 8'h01;
    localparam logic [7:0] SUB_ROOT_JNI_LOC  = 8'h02;
    localparam logic [7:0] SUB_ROOT_JFRAME   = 8'h03;
    localparam logic [7:0] SUB_ROOT_NSTACK   = 8'h04;
    localparam logic [7:0] SUB_ROOT_STICKY   = 8'h05;
    localparam logic [7:0] SUB_ROOT_TBLOCK   = 8'h06;
    localparam logic [7:0] SUB_ROOT_MONITOR  = 8'h07;
    localparam logic [7:0] SUB_ROOT_THREAD   = 8'h08;
    localparam logic [7:0] SUB_ROOT_INTERN   = 8'h89;
    localparam logic [7:0] SUB_ROOT_FINAL    = 8'h8a;
    localparam logic [7:0] SUB_ROOT_DEBUGGER = 8'h8b;
    localparam logic [7:0] SUB_ROOT_REFCLEAN = 8'h8c;
    localparam logic [7:0] SUB_ROOT_VMINT    = 8'h8d;
    localparam logic [7:0] SUB_ROOT_JNIMON   = 8'h8e;
    localparam logic [7:0] SUB_UNREACHABLE   = 8'h90;
    localparam logic [7:0] SUB_PRIM_NODATA   = 8'hc3;
    localparam logic [7:0] SUB_CLASS_DUMP    = 8'h20;
    localparam logic [7:0] SUB_INSTANCE      = 8'h21;
    localparam logic [7:0] SUB_OBJ_ARRAY     = 8'h22;
    localparam logic [7:0] SUB_PRIM_ARRAY    = 8'h23;
    localparam logic [7:0] SUB_HEAP_INFO     = 8'hfe;

    // heap type bytes of system heaps
    localparam logic [7:0] HEAP_ZYGOTE = 8'h5A;
    localparam logic [7:0] HEAP_IMAGE  = 8'h49;

    // basic type codes
    localparam logic [7:0] TY_OBJECT  = 8'd2;
    localparam logic [7:0] TY_BOOLEAN = 8'd4;
    localparam logic [7:0] TY_CHAR    = 8'd5;
    localparam logic [7:0] TY_FLOAT   = 8'd6;
    localparam logic [7:0] TY_DOUBLE  = 8'd7;
    localparam logic [7:0] TY_BYTE    = 8'd8;
    localparam logic [7:0] TY_SHORT   = 8'd9;
    localparam logic [7:0] TY_INT     = 8'd10;
    localparam logic [7:0] TY_LONG    = 8'd11;

    typedef enum logic [PH_W-1:0] {
        PH_TAG       = PH_W'(1) << 0,
        PH_HDR       = PH_W'(1) << 1,
        PH_PASS      = PH_W'(1) << 2,
        PH_SUB       = PH_W'(1) << 3,
        PH_SKIP      = PH_W'(1) << 4,
        PH_STOP      = PH_W'(1) << 5,
        PH_INST_HEAD = PH_W'(1) << 6,
        PH_INST_SIZE = PH_W'(1) << 7,
        PH_OARR_HEAD = PH_W'(1) << 8,
        PH_OARR_LEN  = PH_W'(1) << 9,
        PH_PARR_HEAD = PH_W'(1) << 10,
        PH_PARR_LEN  = PH_W'(1) << 11,
        PH_PARR_TYPE = PH_W'(1) << 12,
        PH_INFO_HEAD = PH_W'(1) << 13,
        PH_INFO_TYPE = PH_W'(1) << 14,
        PH_CLS_HEAD  = PH_W'(1) << 15,
        PH_CP_COUNT  = PH_W'(1) << 16,
        PH_CP_INDEX  = PH_W'(1) << 17,
        PH_CP_TYPE   = PH_W'(1) << 18,
        PH_CP_VALUE  = PH_W'(1) << 19,
        PH_SF_COUNT  = PH_W'(1) << 20,
        PH_SF_NAME   = PH_W'(1) << 21,
        PH_SF_TYPE   = PH_W'(1) << 22,
        PH_SF_VALUE  = PH_W'(1) << 23,
        PH_IF_COUNT  = PH_W'(1) << 24
    } t_phase;

    typedef struct packed {
        logic       keep;
        logic [7:0] data;
    } t_la;

    typedef struct packed {
        logic [7:0]  data;
        logic        keep;
        logic        eob;
        logic [31:0] sum;
        logic [31:0] adj;
        logic        stop;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] slot;
        logic [2:0]         cnt;
    } t_push;

    function automatic logic [3:0] type_size(input logic [7:0] t, input logic [3:0] id);
        logic [3:0] s;
        case (t)
            TY_OBJECT:          s = id;
            TY_BOOLEAN, TY_BYTE: s = 4'd1;
            TY_CHAR, TY_SHORT:  s = 4'd2;
            TY_FLOAT, TY_INT:   s = 4'd4;
            TY_DOUBLE, TY_LONG: s = 4'd8;
            default:            s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/hdrs_parser.sv
// hdrs_parser: record and sub-record parse state machine with the four-byte lookahead
// depends on hdrs_pkg; hands the result items of each transfer to the output queue
module hdrs_parser #(
    parameter int ID_BYTES = hdrs_pkg::ID_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    output hdrs_pkg::t_push    o_push
);
    import hdrs_pkg::*;

    localparam logic [3:0] ID4 = 4'(ID_BYTES);

    t_phase            r_phase, n_phase, cur;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [31:0]       r_fs, n_fs;
    logic [15:0]       r_ec, n_ec;
    logic              r_sysh, n_sysh;
    logic              r_drop_act, n_drop_act;
    logic              r_heap, n_heap;
    logic [31:0]       r_sum, n_sum;
    logic [31:0]       r_rlen, n_rlen;
    logic              r_stop, n_stop;
    t_la [3:0]         r_la, n_la, lk_mod;
    logic [2:0]        r_fill, n_fill;

    logic              drop, sys, full;
    logic [2:0]        back_cnt, inc, fill_new;
    logic [SKIP_W-1:0] skip_dec, prod;
    logic              skip_done;
    logic [31:0]       fs_shift;
    logic [15:0]       ec_use;
    logic [3:0]        vsz;
    logic [32:0]       sum_ext;
    t_la               entry;
    t_la [4:0]         cand;

    assign skip_dec  = (r_skip != '0) ? r_skip - SKIP_W'(1) : '0;
    assign skip_done = (skip_dec == '0);
    assign fs_shift  = {r_fs[23:0], i_data_byte};

    always_comb begin
        cur        = i_first_byte ? PH_TAG : r_phase;
        n_phase    = cur;
        n_skip     = r_skip;
        n_fs       = r_fs;
        n_ec       = r_ec;
        n_sysh     = r_sysh;
        n_drop_act = r_drop_act;
        n_heap     = r_heap;
        n_sum      = r_sum;
        n_rlen     = r_rlen;
        n_stop     = r_stop;
        lk_mod     = r_la;
        drop       = r_drop_act;
        back_cnt   = '0;
        sys        = 1'b0;
        vsz        = '0;
        prod       = '0;
        ec_use     = r_ec;
        case (cur)
            PH_TAG: begin
                n_sum      = '0;
                n_rlen     = '0;
                n_stop     = 1'b0;
                n_drop_act = 1'b0;
                drop       = 1'b0;
                n_heap     = (i_data_byte == REC_HEAP_DUMP) || (i_data_byte == REC_HEAP_SEGMENT);
                if (n_heap) begin
                    n_phase = PH_HDR;
                    n_skip  = SKIP_W'(8);
                    n_fs    = '0;
                end else begin
                    n_phase = PH_PASS;
                end
            end
            PH_HDR: begin
                if (r_skip <= SKIP_W'(4)) n_rlen = {r_rlen[23:0], i_data_byte};
                n_skip = skip_dec;
                if (skip_done) n_phase = PH_SUB;
            end
            PH_SUB: begin
                n_fs = '0;
                case (i_data_byte)
                    SUB_ROOT_UNKNOWN, SUB_ROOT_STICKY, SUB_ROOT_MONITOR, SUB_ROOT_INTERN,
                    SUB_ROOT_DEBUGGER, SUB_ROOT_VMINT: begin
                        n_phase = PH_SKIP;
                        n_skip  = SKIP_W'(ID_BYTES);
                    end
                    SUB_ROOT_JNI_GLB: begin
                        n_phase = PH_SKIP;
                        n_skip  = SKIP_W'(2 * ID_BYTES);
                    end
                    SUB_ROOT_JNI_LOC, SUB_ROOT_JFRAME, SUB_ROOT_JNIMON, SUB_ROOT_THREAD: begin
                        n_phase = PH_SKIP;
                        n_skip  = SKIP_W'(ID_BYTES + 8);
                    end
                    SUB_ROOT_NSTACK, SUB_ROOT_TBLOCK: begin
                        n_phase = PH_SKIP;
                        n_skip  = SKIP_W'(ID_BYTES + 4);
                    end
                    SUB_ROOT_FINAL, SUB_ROOT_REFCLEAN, SUB_UNREACHABLE, SUB_PRIM_NODATA: begin
                        n_fs       = r_fs;
                        n_phase    = PH_SUB;
                        n_drop_act = 1'b0;
                    end
                    SUB_CLASS_DUMP: begin
                        n_phase = PH_CLS_HEAD;
                        n_skip  = SKIP_W'(7 * ID_BYTES + 8);
                    end
                    SUB_INSTANCE: begin
                        n_drop_act = r_sysh;
                        n_phase    = PH_INST_HEAD;
                        n_skip     = SKIP_W'(2 * ID_BYTES + 4);
                    end
                    SUB_OBJ_ARRAY: begin
                        n_drop_act = r_sysh;
                        n_phase    = PH_OARR_HEAD;
                        n_skip     = SKIP_W'(ID_BYTES + 4);
                    end
                    SUB_PRIM_ARRAY: begin
                        n_drop_act = r_sysh;
                        n_phase    = PH_PARR_HEAD;
                        n_skip     = SKIP_W'(ID_BYTES + 4);
                    end
                    SUB_HEAP_INFO: begin
                        n_phase = PH_INFO_HEAD;
                        n_skip  = SKIP_W'(3);
                    end
                    default: begin
                        n_fs    = r_fs;
                        n_stop  = 1'b1;
                        n_phase = PH_STOP;
                    end
                endcase
                drop = n_drop_act;
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_done) begin
                    n_phase    = PH_SUB;
                    n_drop_act = 1'b0;
                end
            end
            PH_INST_HEAD, PH_OARR_HEAD, PH_PARR_HEAD: begin
                n_skip = skip_dec;
                if (skip_done) begin
                    n_phase = (cur == PH_INST_HEAD) ? PH_INST_SIZE :
                              (cur == PH_OARR_HEAD) ? PH_OARR_LEN : PH_PARR_LEN;
                    n_skip  = SKIP_W'(4);
                    n_fs    = '0;
                end
            end
            PH_INST_SIZE, PH_OARR_LEN: begin
                n_fs   = fs_shift;
                n_skip = skip_dec;
                if (skip_done) begin
                    // object array body: class id then one id per element
                    prod = (cur == PH_INST_SIZE) ? SKIP_W'(fs_shift) :
                           SKIP_W'(ID_BYTES) + SKIP_W'(fs_shift) * SKIP_W'(ID_BYTES);
                    if (prod == '0) begin
                        n_phase    = PH_SUB;
                        n_drop_act = 1'b0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = prod;
                        n_fs    = '0;
                    end
                end
            end
            PH_PARR_LEN: begin
                n_fs   = fs_shift;
                n_skip = skip_dec;
                if (skip_done) n_phase = PH_PARR_TYPE;
            end
            PH_PARR_TYPE: begin
                vsz  = type_size(i_data_byte, ID4);
                prod = SKIP_W'(r_fs) * SKIP_W'(vsz);
                if (prod == '0) begin
                    n_phase    = PH_SUB;
                    n_drop_act = 1'b0;
                end else begin
                    // app heap: element data only is dropped, uncounted
                    if (!r_sysh) n_drop_act = 1'b1;
                    n_phase = PH_SKIP;
                    n_skip  = prod;
                    n_fs    = '0;
                end
            end
            PH_INFO_HEAD: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = PH_INFO_TYPE;
            end
            PH_INFO_TYPE: begin
                sys    = (i_data_byte == HEAP_ZYGOTE) || (i_data_byte == HEAP_IMAGE);
                n_sysh = sys;
                if (sys) begin
                    // retro-drop the tag and header still held in the lookahead
                    for (int i = 0; i < 4; i++) begin
                        if ((3'(i) < r_fill) && r_la[i].keep) begin
                            lk_mod[i].keep = 1'b0;
                            back_cnt       = back_cnt + 3'd1;
                        end
                    end
                    n_drop_act = 1'b1;
                    drop       = 1'b1;
                end
                n_phase = PH_SKIP;
                n_skip  = SKIP_W'(ID_BYTES);
                n_fs    = '0;
            end
            PH_CLS_HEAD: begin
                n_skip = skip_dec;
                if (skip_done) begin
                    n_phase = PH_CP_COUNT;
                    n_skip  = SKIP_W'(2);
                    n_fs    = '0;
                end
            end
            PH_CP_COUNT, PH_CP_TYPE, PH_CP_VALUE: begin
                logic nxt;
                nxt = 1'b0;
                if (cur == PH_CP_COUNT) begin
                    n_fs   = fs_shift;
                    n_skip = skip_dec;
                    if (skip_done) begin
                        ec_use = fs_shift[15:0];
                        n_ec   = ec_use;
                        nxt    = 1'b1;
                    end
                end else if (cur == PH_CP_TYPE) begin
                    vsz = type_size(i_data_byte, ID4);
                    if (vsz == '0) nxt = 1'b1;
                    else begin
                        n_phase = PH_CP_VALUE;
                        n_skip  = SKIP_W'(vsz);
                        n_fs    = '0;
                    end
                end else begin
                    n_skip = skip_dec;
                    if (skip_done) nxt = 1'b1;
                end
                if (nxt) begin
                    n_fs = '0;
                    if (ec_use == '0) begin
                        n_phase = PH_SF_COUNT;
                        n_skip  = SKIP_W'(2);
                    end else begin
                        n_ec    = ec_use - 16'd1;
                        n_phase = PH_CP_INDEX;
                        n_skip  = SKIP_W'(2);
                    end
                end
            end
            PH_CP_INDEX: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = PH_CP_TYPE;
            end
            PH_SF_COUNT, PH_SF_TYPE, PH_SF_VALUE: begin
                logic nxt;
                nxt = 1'b0;
                if (cur == PH_SF_COUNT) begin
                    n_fs   = fs_shift;
                    n_skip = skip_dec;
                    if (skip_done) begin
                        ec_use = fs_shift[15:0];
                        n_ec   = ec_use;
                        nxt    = 1'b1;
                    end
                end else if (cur == PH_SF_TYPE) begin
                    vsz = type_size(i_data_byte, ID4);
                    if (vsz == '0) nxt = 1'b1;
                    else begin
                        n_phase = PH_SF_VALUE;
                        n_skip  = SKIP_W'(vsz);
                        n_fs    = '0;
                    end
                end else begin
                    n_skip = skip_dec;
                    if (skip_done) nxt = 1'b1;
                end
                if (nxt) begin
                    n_fs = '0;
                    if (ec_use == '0) begin
                        n_phase = PH_IF_COUNT;
                        n_skip  = SKIP_W'(2);
                    end else begin
                        n_ec    = ec_use - 16'd1;
                        n_phase = PH_SF_NAME;
                        n_skip  = SKIP_W'(ID_BYTES);
                    end
                end
            end
            PH_SF_NAME: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = PH_SF_TYPE;
            end
            PH_IF_COUNT: begin
                n_fs   = fs_shift;
                n_skip = skip_dec;
                if (skip_done) begin
                    prod = SKIP_W'(fs_shift[15:0]) * SKIP_W'(ID_BYTES + 1);
                    if (prod == '0) begin
                        n_phase    = PH_SUB;
                        n_drop_act = 1'b0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = prod;
                        n_fs    = '0;
                    end
                end
            end
            default: drop = 1'b0;
        endcase

        // saturating strip count: retro-dropped bytes plus this one
        inc     = back_cnt + {2'b0, drop && n_sysh};
        sum_ext = {1'b0, n_sum} + 33'(inc);
        n_sum   = sum_ext[32] ? '1 : sum_ext[31:0];

        // lookahead shift and result build
        entry.keep = ~drop;
        entry.data = i_data_byte;
        full       = (r_fill == 3'd4);
        n_la       = lk_mod;
        if (full) begin
            n_la     = {entry, lk_mod[3], lk_mod[2], lk_mod[1]};
            fill_new = 3'd4;
        end else begin
            n_la[r_fill[1:0]] = entry;
            fill_new          = r_fill + 3'd1;
        end
        cand       = {n_la, lk_mod[0]};
        o_push.cnt = {2'b0, full} + (i_last_byte ? fill_new : 3'd0);
        for (int k = 0; k < MAX_RES; k++) begin
            t_la src;
            src = full ? cand[k] : ((k < 4) ? cand[k + 1] : cand[MAX_RES-1]);
            o_push.slot[k].data = src.data;
            o_push.slot[k].keep = src.keep;
            o_push.slot[k].eob  = i_last_byte && (3'(k) == o_push.cnt - 3'd1);
            o_push.slot[k].sum  = n_sum;
            o_push.slot[k].adj  = n_heap ? n_rlen - n_sum : '0;
            o_push.slot[k].stop = n_stop;
        end
        n_fill = fill_new;
        if (i_last_byte) begin
            n_fill     = '0;
            n_phase    = PH_TAG;
            n_drop_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_skip     <= '0;
            r_fs       <= '0;
            r_ec       <= '0;
            r_sysh     <= 1'b0;
            r_drop_act <= 1'b0;
            r_heap     <= 1'b0;
            r_sum      <= '0;
            r_rlen     <= '0;
            r_stop     <= 1'b0;
            r_fill     <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_fs       <= n_fs;
            r_ec       <= n_ec;
            r_sysh     <= n_sysh;
            r_drop_act <= n_drop_act;
            r_heap     <= n_heap;
            r_sum      <= n_sum;
            r_rlen     <= n_rlen;
            r_stop     <= n_stop;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_la <= n_la;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4) else $error("lookahead overfilled");
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_fill == 3'd0) && (r_phase == PH_TAG))
        else $error("lookahead not flushed at buffer end");
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |-> (o_push.cnt != 3'd0) && (o_push.cnt <= 3'd5))
        else $error("buffer end gave no result");

endmodule

FILE: sv/hdrs_outq.sv
// hdrs_outq: result queue that takes up to five items per transfer and gives one per cycle while the sink is ready
// depends on hdrs_pkg
module hdrs_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  hdrs_pkg::t_push    i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output hdrs_pkg::t_res     o_res
);
    import hdrs_pkg::*;

    t_res [QDEPTH-1:0]  r_mem;
    logic [QPTR_W-1:0]  r_head, r_tail;
    logic [QPTR_W:0]    r_cnt, n_cnt;
    logic               pop;
    logic [2:0]         push_cnt;

    assign push_cnt = i_accept ? i_push.cnt : 3'd0;
    assign o_valid  = (r_cnt != '0);
    assign pop      = o_valid && i_ready;
    assign o_res    = r_mem[r_head];
    assign o_room   = (r_cnt <= (QPTR_W+1)'(QDEPTH - MAX_RES));
    assign n_cnt    = r_cnt + (QPTR_W+1)'(push_cnt) - (QPTR_W+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= r_head + QPTR_W'(pop);
            r_tail <= r_tail + QPTR_W'(push_cnt);
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < push_cnt) r_mem[r_tail + QPTR_W'(k)] <= i_push.slot[k];
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH)) else $error("result queue overflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt == $past(r_cnt) + (QPTR_W+1)'($past(push_cnt)) - (QPTR_W+1)'($past(pop)))
        else $error("result queue count slipped");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_tail - r_head) == r_cnt[QPTR_W-1:0]) else $error("queue pointers disagree");

endmodule

FILE: sv/heap_dump_record_stripper_core.sv
// heap_dump_record_stripper_core: top level of the heap-dump record stripper
// depends on hdrs_pkg, hdrs_parser and hdrs_outq
// a byte waits in the four-entry lookahead until a later byte shifts it out or the buffer's
// last byte flushes it, then in the result queue; throughput one byte per cycle while o_ready is high
// a buffer end pushes up to five results at once into the eight-entry queue, which stalls
// input until it drains to three; synchronous active-low reset empties the queue and
// lookahead and returns the parser to the record tag
module heap_dump_record_stripper_core #(
    parameter int ID_BYTES = hdrs_pkg::ID_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_keep,
    output logic        o_end_of_buffer,
    output logic [31:0] o_stripped_total,
    output logic [31:0] o_adjusted_length,
    output logic        o_parse_stopped
);
    import hdrs_pkg::*;

    logic  accept;
    t_push push;
    t_res  res;

    // an input transfer happens when input is valid and the queue has room for a full flush
    assign accept = i_valid && o_ready;

    hdrs_parser #(
        .ID_BYTES (ID_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_push       (push)
    );

    // results wait here, so input keeps flowing while the sink stalls, until the queue holds more than three
    hdrs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_push   (push),
        .o_room   (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (res)
    );

    assign o_out_byte        = res.data;
    assign o_keep            = res.keep;
    assign o_end_of_buffer   = res.eob;
    assign o_stripped_total  = res.sum;
    assign o_adjusted_length = res.adj;
    assign o_parse_stopped   = res.stop;

endmodule
